// ===== hdl/searchable_double_ended_queue_assert.svh =====
// assertion macros used by the queue top module
`ifndef SEARCHABLE_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define SEARCHABLE_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SDEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdeq assertion failed");

// next-cycle implication, checked out of reset
`define SDEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdeq assertion failed");

`endif

// ===== hdl/sdeq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdeq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_POP_FRONT  = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // per-cell move controls, at most one set in a cycle
    typedef struct packed {
        logic take_left;
        logic take_right;
        logic load;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/searchable_double_ended_queue.sv =====
// latency: a result word is valid the cycle after its request word is accepted
// throughput: one request per cycle while in_stall is low; every cell shifts or compares at once
// a search compares all cells at once and picks the first hit from the front
// in_stall is high only while a finished result is held by out_stall
// reset (rst_n low, asynchronous) empties the queue and drops any pending result
`timescale 1ns / 1ps
`default_nettype none
`include "searchable_double_ended_queue_assert.svh"

module searchable_double_ended_queue
    import sdeq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [WORD_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [STATUS_W-1:0]           status,
    output logic signed [WORD_W-1:0]      popped_value,
    output logic [POS_W-1:0]              found_position
);

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     push_front_ok;
    logic                     push_back_ok;
    logic                     pop_front_ok;
    logic                     pop_back_ok;

    logic [CNT_W-1:0]         occupancy_reg;
    logic [CNT_W-1:0]         occupancy_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [WORD_W-1:0] popped_reg;
    logic signed [WORD_W-1:0] popped_next;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;

    logic signed [WORD_W-1:0] cell_word [CAPACITY];
    logic [CAPACITY-1:0]      hit_vec;
    logic [CAPACITY-1:0]      first_hit;
    logic [CNT_W-1:0]         hit_pos;
    logic [IDX_W-1:0]         back_idx;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (occupancy_reg == CNT_W'(CAPACITY));
    assign empty    = (occupancy_reg == '0);

    assign push_front_ok = accept && (operation == OP_PUSH_FRONT) && !full;
    assign push_back_ok  = accept && (operation == OP_PUSH_BACK) && !full;
    assign pop_front_ok  = accept && (operation == OP_POP_FRONT) && !empty;
    assign pop_back_ok   = accept && (operation == OP_POP_BACK) && !empty;

    assign back_idx = IDX_W'(occupancy_reg - CNT_W'(1));

    // row of cells, slot 0 is the front
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_ctl_t                ctl;
        logic signed [WORD_W-1:0] left_word;
        logic signed [WORD_W-1:0] right_word;

        assign ctl.take_left  = push_front_ok;
        assign ctl.take_right = pop_front_ok;
        assign ctl.load       = push_back_ok && (occupancy_reg == CNT_W'(i));

        if (i == 0)
        begin : g_front
            assign left_word = value;
        end
        else
        begin : g_inner
            assign left_word = cell_word[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_back
            assign right_word = cell_word[i];
        end
        else
        begin : g_rest
            assign right_word = cell_word[i+1];
        end

        sdeq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .left_word  (left_word),
            .right_word (right_word),
            .value      (value),
            .occupied   (occupancy_reg > CNT_W'(i)),
            .word       (cell_word[i]),
            .hit        (hit_vec[i])
        );
    end

    // isolate the lowest set hit, then encode it
    assign first_hit = hit_vec & (~hit_vec + CAPACITY'(1));

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_pos = hit_pos | (first_hit[i] ? CNT_W'(i + 1) : '0);
        end
    end

    always_comb
    begin
        status_next    = ST_OK;
        popped_next    = '0;
        pos_next       = '0;
        occupancy_next = occupancy_reg;
        unique case (operation)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    occupancy_next = occupancy_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    occupancy_next = occupancy_reg - CNT_W'(1);
                    popped_next    = (operation == OP_POP_FRONT) ? cell_word[0]
                                                                : cell_word[back_idx];
                end
            end
            OP_SEARCH:
            begin
                if (hit_vec == '0)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    pos_next = POS_W'(hit_pos);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                occupancy_reg <= occupancy_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            pos_reg    <= pos_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign popped_value   = popped_reg;
    assign found_position = pos_reg;

    `SDEQ_ASSERT_NOW(a_occ_bound, 1'b1, occupancy_reg <= CNT_W'(CAPACITY))
    `SDEQ_ASSERT_NEXT(a_push_grows, push_front_ok || push_back_ok,
        occupancy_reg == CNT_W'($past(occupancy_reg) + CNT_W'(1)))
    `SDEQ_ASSERT_NEXT(a_pop_empty,
        accept && empty && (operation == OP_POP_FRONT || operation == OP_POP_BACK),
        out_valid && status == ST_EMPTY && popped_value == '0)
    `SDEQ_ASSERT_NOW(a_miss_no_pos, out_valid && status == ST_NOT_FOUND,
        found_position == '0)

endmodule

`default_nettype wire

// ===== hdl/sdeq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdeq_cell
    import sdeq_pkg::*;
(
    input  wire logic                     clk,
    input  wire cell_ctl_t                ctl,
    input  wire logic signed [WORD_W-1:0] left_word,
    input  wire logic signed [WORD_W-1:0] right_word,
    input  wire logic signed [WORD_W-1:0] value,
    input  wire logic                     occupied,
    output logic signed [WORD_W-1:0]      word,
    output logic                          hit
);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb
    begin
        priority if (ctl.take_left)
        begin
            word_next = left_word;
        end
        else if (ctl.take_right)
        begin
            word_next = right_word;
        end
        else if (ctl.load)
        begin
            word_next = value;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign hit  = occupied && (word_reg == value);

endmodule

`default_nettype wire

// ===== test/sdeq_checker.sv =====
`timescale 1ns / 1ps

module sdeq_checker
    import sdeq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [WORD_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [STATUS_W-1:0]      status,
    input  logic signed [WORD_W-1:0] popped_value,
    input  logic [POS_W-1:0]         found_position,
    output int                       fail_count,
    output int                       pending_count
);

    typedef struct {
        status_t                  status;
        logic signed [WORD_W-1:0] popped;
        logic [POS_W-1:0]         position;
    } deque_reply_t;

    // shadow copy of the queue, slot 0 is the front
    logic signed [WORD_W-1:0] slots [CAPACITY];
    int                       fill;
    deque_reply_t             expected_replies [$];
    int                       errors;

    initial
    begin
        fill          = 0;
        errors        = 0;
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic deque_reply_t apply_request(input logic [OP_W-1:0] op,
                                                   input logic signed [WORD_W-1:0] val);
        deque_reply_t r;
        r.status   = ST_OK;
        r.popped   = '0;
        r.position = '0;
        case (op)
            OP_PUSH_FRONT:
                if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = fill; i > 0; i--)
                        slots[i] = slots[i-1];
                    slots[0] = val;
                    fill++;
                end
            OP_PUSH_BACK:
                if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    slots[fill] = val;
                    fill++;
                end
            OP_POP_FRONT:
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped = slots[0];
                    for (int i = 0; i < fill - 1; i++)
                        slots[i] = slots[i+1];
                    fill--;
                end
            OP_POP_BACK:
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    fill--;
                    r.popped = slots[fill];
                end
            OP_SEARCH:
            begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < fill; i++)
                    if (r.status == ST_NOT_FOUND && slots[i] == val)
                    begin
                        r.status   = ST_OK;
                        r.position = POS_W'(i + 1);
                    end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        deque_reply_t want;
        if (!rst_n)
        begin
            fill = 0;
            foreach (slots[i])
                slots[i] = '0;
            expected_replies.delete();
        end
        else
        begin
            // result first: a word accepted now belongs to an earlier request
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("result word with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, status);
                        errors++;
                    end
                    if (popped_value !== want.popped)
                    begin
                        $error("popped_value expected %0d actual %0d",
                               want.popped, popped_value);
                        errors++;
                    end
                    if (found_position !== want.position)
                    begin
                        $error("found_position expected %0d actual %0d",
                               want.position, found_position);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_replies.push_back(apply_request(operation, value));
        end
        pending_count <= expected_replies.size();
        fail_count    <= errors;
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb
    import sdeq_pkg::*;
();

    localparam int RANDOM_WORDS = 1200;
    localparam int QUIET_TAIL   = 200;
    localparam int CYCLE_LIMIT  = 400000;

    localparam int MODE_FILL   = 0;
    localparam int MODE_DRAIN  = 1;
    localparam int MODE_MIXED  = 2;
    localparam int MODE_SEARCH = 3;

    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     in_valid       = 1'b0;
    logic [OP_W-1:0]          operation      = '0;
    logic signed [WORD_W-1:0] value          = '0;
    logic                     out_stall      = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] popped_value;
    logic [POS_W-1:0]         found_position;

    int fail_count;
    int pending_count;
    int cycle_count    = 0;
    int stall_left     = 0;
    bit sender_idle    = 1'b0;
    bit receiver_idle  = 1'b0;

    searchable_double_ended_queue dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .popped_value   (popped_value),
        .found_position (found_position)
    );

    sdeq_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .popped_value   (popped_value),
        .found_position (found_position),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side backpressure in random bursts, started only while receiver_idle is set
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (receiver_idle && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic issue_request(input logic [OP_W-1:0] op,
                                 input logic signed [WORD_W-1:0] val);
        int gap;
        in_valid  <= 1'b1;
        operation <= op;
        value     <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (sender_idle && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                if (r < 40)      return OP_PUSH_FRONT;
                else if (r < 80) return OP_PUSH_BACK;
                else if (r < 90) return OP_SEARCH;
                else if (r < 97) return r[0] ? OP_POP_FRONT : OP_POP_BACK;
            MODE_DRAIN:
                if (r < 40)      return OP_POP_FRONT;
                else if (r < 80) return OP_POP_BACK;
                else if (r < 90) return r[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else if (r < 97) return OP_SEARCH;
            MODE_SEARCH:
                if (r < 50)      return OP_SEARCH;
                else if (r < 70) return OP_PUSH_BACK;
                else if (r < 85) return OP_PUSH_FRONT;
                else if (r < 97) return r[0] ? OP_POP_FRONT : OP_POP_BACK;
            default:
                if (r < 97)      return OP_W'($urandom_range(OP_PUSH_FRONT, OP_SEARCH));
        endcase
        return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    // a small pool of values so searches hit, duplicates included
    function automatic logic signed [WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            case ($urandom_range(0, 5))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return -1;
                default: return WORD_W'($urandom_range(0, 5));
            endcase
        end
        return $urandom;
    endfunction

    initial
    begin
        int sent;
        int mode;
        int run_len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corners and the unused codes
        issue_request(OP_POP_FRONT, 32'sd7);
        issue_request(OP_POP_BACK, -32'sd7);
        issue_request(OP_SEARCH, 32'sd0);
        issue_request(OP_UNUSED_LO, WORD_MAX);
        issue_request(OP_UNUSED_MID, WORD_MIN);
        issue_request(OP_UNUSED_HI, -32'sd1);
        // queue becomes 0, min, max, -1, min
        issue_request(OP_PUSH_FRONT, WORD_MIN);
        issue_request(OP_PUSH_BACK, WORD_MAX);
        issue_request(OP_PUSH_FRONT, 32'sd0);
        issue_request(OP_PUSH_BACK, -32'sd1);
        issue_request(OP_PUSH_BACK, WORD_MIN);
        // first match wins over the later duplicate
        issue_request(OP_SEARCH, WORD_MIN);
        issue_request(OP_SEARCH, -32'sd1);
        issue_request(OP_SEARCH, 32'sd0);
        issue_request(OP_SEARCH, 32'sh7fff_fffe);
        issue_request(OP_POP_FRONT, '0);
        issue_request(OP_POP_BACK, '0);
        issue_request(OP_SEARCH, WORD_MIN);
        drain_replies();

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            mode    = $urandom_range(MODE_FILL, MODE_SEARCH);
            run_len = $urandom_range(20, 60);
            if (RANDOM_WORDS - sent <= QUIET_TAIL)
            begin
                sender_idle   = 1'b0;
                receiver_idle = 1'b0;
            end
            else
            begin
                sender_idle   = $urandom_range(0, 3) != 0;
                receiver_idle = $urandom_range(0, 3) != 0;
            end
            repeat (run_len)
            begin
                issue_request(pick_op(mode), pick_value());
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                drain_replies();
        end

        drain_replies();
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sdeq_pkg.sv
hdl/sdeq_cell.sv
hdl/searchable_double_ended_queue.sv
test/sdeq_checker.sv
test/tb.sv
